/* src/wqs_pkg.sv */
// ============================================================================
// Water quality scorer package
// Shared payload types, fixed limits, status codes and divider widths.
// ============================================================================
`default_nettype none

package wqs_pkg;

    // Readings of one beat on the input channel.
    typedef struct packed {
        logic [10:0]        ph_value;
        logic               ph_ok;
        logic [11:0]        solids_ppm;
        logic               solids_ok;
        logic signed [11:0] temp_tenths;
        logic               temp_ok;
        logic [9:0]         turbidity_ntu;
        logic               turbidity_ok;
    } t_in;

    // Result of one beat on the output channel.
    typedef struct packed {
        logic [6:0] water_score;
        logic [1:0] water_status;
        logic [1:0] overall_status;
        logic [4:0] reason_flags;
        logic [1:0] ph_status;
        logic [1:0] solids_status;
        logic [1:0] temp_status;
        logic [1:0] turbidity_status;
    } t_out;

    // Sensor classes.
    localparam logic [1:0] ST_SAFE   = 2'd0;
    localparam logic [1:0] ST_WARN   = 2'd1;
    localparam logic [1:0] ST_DANGER = 2'd2;
    localparam logic [1:0] ST_FAIL   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PH_SAFE_LOW  = 3'd0;
    localparam logic [2:0] CFG_PH_SAFE_HIGH = 3'd1;
    localparam logic [2:0] CFG_PH_WARN_LOW  = 3'd2;
    localparam logic [2:0] CFG_PH_WARN_HIGH = 3'd3;
    localparam logic [2:0] CFG_SOL_SAFE     = 3'd4;
    localparam logic [2:0] CFG_SOL_WARN     = 3'd5;
    localparam logic [2:0] CFG_TEMP_SAFE    = 3'd6;
    localparam logic [2:0] CFG_TEMP_WARN    = 3'd7;

    // Fixed limits and end points.
    localparam int TURB_SAFE_NTU = 5;
    localparam int TURB_WARN_NTU = 10;
    localparam int PH_END        = 1400;
    localparam int SOLIDS_END    = 1000;
    localparam int TEMP_END      = 600;
    localparam int TURB_END      = 100;
    localparam int FULL_Q8       = 25600;
    localparam int HALF_Q8       = 12800;

    // Divider geometry: distance and span are 12 bits, quotient up to 12800.
    localparam int DW      = 12;
    localparam int QW      = 14;
    localparam int NW      = DW + QW;
    localparam int DIV_STG = QW + 1;

endpackage

`default_nettype wire

/* src/wqs_div_lane.sv */
// ============================================================================
// Scaled division lane
// Computes floor(dist * 12800 / span) with one multiply stage followed by one
// restoring quotient bit per stage.
// ============================================================================
`default_nettype none

module wqs_div_lane (
    input  wire logic                       i_clk,
    input  wire logic [wqs_pkg::DIV_STG-1:0] i_load,
    input  wire logic [wqs_pkg::DW-1:0]     i_dist,
    input  wire logic [wqs_pkg::DW-1:0]     i_span,
    output logic      [wqs_pkg::QW-1:0]     o_quot
);
    import wqs_pkg::*;

    logic [NW-1:0] r_rem [DIV_STG];
    logic [QW-1:0] r_q   [DIV_STG];
    logic [DW-1:0] r_sp  [DIV_STG];

    // Scale the distance to the half-score numerator, then settle one
    // quotient bit per stage, most significant first.
    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_rem[0] <= NW'(i_dist) * NW'(HALF_Q8);
            r_q[0]   <= '0;
            r_sp[0]  <= i_span;
        end
        for (int j = 1; j < DIV_STG; j++) begin
            if (i_load[j]) begin
                if (r_rem[j-1] >= (NW'(r_sp[j-1]) << (QW - j))) begin
                    r_rem[j] <= r_rem[j-1] - (NW'(r_sp[j-1]) << (QW - j));
                    r_q[j]   <= r_q[j-1] | (QW'(1) << (QW - j));
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_q[j]   <= r_q[j-1];
                end
                r_sp[j] <= r_sp[j-1];
            end
        end
    end

    assign o_quot = r_q[DIV_STG-1];

endmodule

`default_nettype wire

/* src/water_quality_scorer.sv */
// ============================================================================
// Water quality scorer
// Classifies four sensor readings, scores them by interpolation and reports
// the mean score, the worst class, the fault status and reason flags.
// ============================================================================
//
//  Channel  Valid     Stall     Payload     Beat taken when
//  -------  --------  --------  ----------  -----------------------------
//  input    i_valid   o_stall   i_in        i_valid high, o_stall low
//  output   o_valid   i_stall   o_out       o_valid high, i_stall low
//  config   i_cfg_we  -         i_cfg_data  i_cfg_we high (i_cfg_idx)
//
//  One beat is accepted per cycle while o_stall is low; there are 18
//  register stages, most of them in the divider lanes: one multiply stage
//  and fourteen restoring quotient stages, between classification and the
//  sum and mean stages. Each stage holds its own valid bit, so bubbles
//  close up and a stalled output still lets earlier stages fill. Reset
//  clears the valid bits and loads the default limits.
//
`default_nettype none

module water_quality_scorer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire wqs_pkg::t_in  i_in,
    output logic               o_valid,
    input  wire logic          i_stall,
    output wqs_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [11:0]   i_cfg_data
);
    import wqs_pkg::*;

    localparam int NS  = DIV_STG + 3;
    localparam int S_E = DIV_STG + 1;
    localparam int S_F = DIV_STG + 2;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_HALF,
        BASE_FULL
    } t_base;

    // Result of classifying one reading.
    typedef struct packed {
        logic [1:0]    st;
        t_base         base;
        logic          neg;
        logic [DW-1:0] delta;
        logic [DW-1:0] span;
    } t_cls;

    // Per-beat control carried beside the divider lanes.
    typedef struct packed {
        logic [3:0]      ok;
        logic [3:0][1:0] st;
        logic [3:0][1:0] base;
        logic [3:0]      neg;
        logic [4:0]      flags;
        logic [1:0]      worst;
        logic [1:0]      overall;
        logic [2:0]      count;
    } t_side;

    // Configuration registers.
    logic [10:0]        r_ph_sl, r_ph_sh, r_ph_wl, r_ph_wh;
    logic [11:0]        r_sol_safe, r_sol_warn;
    logic signed [11:0] r_tmp_safe, r_tmp_warn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_sl    <= 11'd650;
            r_ph_sh    <= 11'd850;
            r_ph_wl    <= 11'd600;
            r_ph_wh    <= 11'd900;
            r_sol_safe <= 12'd300;
            r_sol_warn <= 12'd600;
            r_tmp_safe <= 12'sd300;
            r_tmp_warn <= 12'sd400;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PH_SAFE_LOW:  r_ph_sl    <= i_cfg_data[10:0];
                CFG_PH_SAFE_HIGH: r_ph_sh    <= i_cfg_data[10:0];
                CFG_PH_WARN_LOW:  r_ph_wl    <= i_cfg_data[10:0];
                CFG_PH_WARN_HIGH: r_ph_wh    <= i_cfg_data[10:0];
                CFG_SOL_SAFE:     r_sol_safe <= i_cfg_data;
                CFG_SOL_WARN:     r_sol_warn <= i_cfg_data;
                CFG_TEMP_SAFE:    r_tmp_safe <= $signed(i_cfg_data);
                CFG_TEMP_WARN:    r_tmp_warn <= $signed(i_cfg_data);
                default:          r_tmp_warn <= r_tmp_warn;
            endcase
        end
    end

    // Classifier for readings with an upper limit pair.
    function automatic t_cls up_class(input logic signed [13:0] x,
                                      input logic signed [13:0] safe,
                                      input logic signed [13:0] warn,
                                      input logic signed [13:0] endv);
        t_cls c;
        c.st    = ST_SAFE;
        c.base  = BASE_FULL;
        c.neg   = 1'b0;
        c.delta = '0;
        c.span  = DW'(1);
        if (x <= safe) begin
            c.st = ST_SAFE;
        end else if (x <= warn) begin
            c.st    = ST_WARN;
            c.neg   = 1'b1;
            c.delta = DW'(x - safe);
            c.span  = DW'(warn - safe);
        end else if (x >= endv) begin
            c.st   = ST_DANGER;
            c.base = BASE_ZERO;
        end else begin
            c.st    = ST_DANGER;
            c.base  = BASE_HALF;
            c.neg   = 1'b1;
            c.delta = DW'(x - warn);
            c.span  = DW'(endv - warn);
        end
        return c;
    endfunction

    // Classifier for pH with its two-sided window.
    function automatic t_cls ph_class(input logic signed [13:0] x,
                                      input logic signed [13:0] sl,
                                      input logic signed [13:0] sh,
                                      input logic signed [13:0] wl,
                                      input logic signed [13:0] wh);
        t_cls c;
        c.st    = ST_SAFE;
        c.base  = BASE_FULL;
        c.neg   = 1'b0;
        c.delta = '0;
        c.span  = DW'(1);
        if (x >= sl && x <= sh) begin
            c.st = ST_SAFE;
        end else if (x >= wl && x < sl) begin
            c.st    = ST_WARN;
            c.base  = BASE_HALF;
            c.delta = DW'(x - wl);
            c.span  = DW'(sl - wl);
        end else if (x > sh && x <= wh) begin
            c.st    = ST_WARN;
            c.neg   = 1'b1;
            c.delta = DW'(x - sh);
            c.span  = DW'(wh - sh);
        end else if (x < wl) begin
            c.st    = ST_DANGER;
            c.base  = BASE_ZERO;
            c.delta = DW'(x);
            c.span  = DW'(wl);
        end else if (x >= 14'(PH_END)) begin
            c.st   = ST_DANGER;
            c.base = BASE_ZERO;
        end else begin
            c.st    = ST_DANGER;
            c.base  = BASE_HALF;
            c.neg   = 1'b1;
            c.delta = DW'(x - wh);
            c.span  = DW'(14'(PH_END) - wh);
        end
        return c;
    endfunction

    // Handshake: each stage takes a beat when empty or when the next moves.
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;
    logic          w_acc;

    assign w_rdy[NS] = !i_stall;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign w_acc   = i_valid && w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= (k == 0) ? w_acc : r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: classify the four readings.
    t_cls  w_cls [4];
    t_side n_side;
    logic  w_ph_low;

    always_comb begin
        w_cls[0] = ph_class($signed({3'b000, i_in.ph_value}),
                            $signed({3'b000, r_ph_sl}), $signed({3'b000, r_ph_sh}),
                            $signed({3'b000, r_ph_wl}), $signed({3'b000, r_ph_wh}));
        w_cls[1] = up_class($signed({2'b00, i_in.solids_ppm}),
                            $signed({2'b00, r_sol_safe}), $signed({2'b00, r_sol_warn}),
                            14'(SOLIDS_END));
        w_cls[2] = up_class({{2{i_in.temp_tenths[11]}}, i_in.temp_tenths},
                            {{2{r_tmp_safe[11]}}, r_tmp_safe},
                            {{2{r_tmp_warn[11]}}, r_tmp_warn},
                            14'(TEMP_END));
        w_cls[3] = up_class($signed({4'b0000, i_in.turbidity_ntu}),
                            14'(TURB_SAFE_NTU), 14'(TURB_WARN_NTU), 14'(TURB_END));
        w_ph_low = (i_in.ph_value < r_ph_sl);

        n_side.ok = {i_in.turbidity_ok, i_in.temp_ok, i_in.solids_ok, i_in.ph_ok};
        n_side.count = 3'(n_side.ok[0]) + 3'(n_side.ok[1])
                     + 3'(n_side.ok[2]) + 3'(n_side.ok[3]);
        n_side.worst = ST_SAFE;
        for (int s = 0; s < 4; s++) begin
            n_side.st[s]   = n_side.ok[s] ? w_cls[s].st : ST_FAIL;
            n_side.base[s] = w_cls[s].base;
            n_side.neg[s]  = w_cls[s].neg;
            if (n_side.ok[s] && w_cls[s].st > n_side.worst) begin
                n_side.worst = w_cls[s].st;
            end
        end
        if (n_side.count == 3'd0) begin
            n_side.worst = ST_DANGER;
        end
        n_side.overall = (&n_side.ok) ? n_side.worst : ST_FAIL;

        // Reason flags come from working sensors that are not safe.
        n_side.flags    = '0;
        n_side.flags[0] = n_side.ok[0] && (w_cls[0].st != ST_SAFE) && w_ph_low;
        n_side.flags[1] = n_side.ok[0] && (w_cls[0].st != ST_SAFE) && !w_ph_low;
        n_side.flags[2] = n_side.ok[1] && (w_cls[1].st != ST_SAFE);
        n_side.flags[3] = n_side.ok[2] && (w_cls[2].st != ST_SAFE);
        n_side.flags[4] = n_side.ok[3] && (w_cls[3].st != ST_SAFE);
    end

    logic [DW-1:0] r_dist [4];
    logic [DW-1:0] r_span [4];
    t_side         r_side [DIV_STG+1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int s = 0; s < 4; s++) begin
                r_dist[s] <= w_cls[s].delta;
                r_span[s] <= w_cls[s].span;
            end
            r_side[0] <= n_side;
        end
        for (int k = 1; k <= DIV_STG; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stages 1 to DIV_STG: one divider lane per sensor.
    logic [QW-1:0] w_quot [4];

    for (genvar s = 0; s < 4; s++) begin : g_lane
        wqs_div_lane u_lane (
            .i_clk  (i_clk),
            .i_load (w_rdy[DIV_STG:1]),
            .i_dist (r_dist[s]),
            .i_span (r_span[s]),
            .o_quot (w_quot[s])
        );
    end

    // Stage E: form the scores and add up the working ones.
    logic [14:0] w_score [4];
    logic [16:0] n_sum;
    logic [16:0] r_sum;
    t_side       r_side_e;

    always_comb begin
        n_sum = '0;
        for (int s = 0; s < 4; s++) begin
            unique case (t_base'(r_side[DIV_STG].base[s]))
                BASE_FULL: w_score[s] = 15'(FULL_Q8);
                BASE_HALF: w_score[s] = 15'(HALF_Q8);
                default:   w_score[s] = '0;
            endcase
            w_score[s] = r_side[DIV_STG].neg[s] ? (w_score[s] - 15'(w_quot[s]))
                                                : (w_score[s] + 15'(w_quot[s]));
            if (r_side[DIV_STG].ok[s]) begin
                n_sum = n_sum + 17'(w_score[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_E]) begin
            r_sum    <= n_sum;
            r_side_e <= r_side[DIV_STG];
        end
    end

    // Stage F: mean over the working sensors, then the output register.
    logic [8:0]  w_whole;
    logic [19:0] w_third;
    logic [6:0]  w_mean;
    t_out        n_out;

    always_comb begin
        w_whole = r_sum[16:8];
        w_third = 20'(w_whole) * 20'(683);
        unique case (r_side_e.count)
            3'd1:    w_mean = 7'(w_whole);
            3'd2:    w_mean = 7'(w_whole >> 1);
            3'd3:    w_mean = 7'(w_third >> 11);
            3'd4:    w_mean = 7'(w_whole >> 2);
            default: w_mean = '0;
        endcase
        n_out.water_score      = w_mean;
        n_out.water_status     = r_side_e.worst;
        n_out.overall_status   = r_side_e.overall;
        n_out.reason_flags     = r_side_e.flags;
        n_out.ph_status        = r_side_e.st[0];
        n_out.solids_status    = r_side_e.st[1];
        n_out.temp_status      = r_side_e.st[2];
        n_out.turbidity_status = r_side_e.st[3];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_F]) begin
            o_out <= n_out;
        end
    end

`ifndef SYNTH
    // An overall status other than error means every sensor reported.
    a_overall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.overall_status != ST_FAIL |->
            o_out.ph_status != ST_FAIL && o_out.solids_status != ST_FAIL &&
            o_out.temp_status != ST_FAIL && o_out.turbidity_status != ST_FAIL)
        else $error("overall status hides a failed sensor");

    // The mean never exceeds a full score.
    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.water_score <= 7'd100)
        else $error("water score above full scale");

    // An empty pipeline never stalls its input.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld == '0 |-> !o_stall)
        else $error("empty pipeline stalls input");
`endif

endmodule

`default_nettype wire

/* test/tb_water_quality_scorer.sv */
// ============================================================================
// Water quality scorer testbench
// Drives reading sets through the block under random burst and stall
// patterns, predicts each result from its own scoring model and compares
// every result beat field by field, over several limit settings.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb_water_quality_scorer;
    import wqs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    t_in          in_beat;
    logic         out_valid;
    logic         out_stall;
    t_out         out_beat;
    logic         cfg_we;
    logic [2:0]   cfg_idx;
    logic [11:0]  cfg_data;

    // Local copy of the limit registers.
    int lim_ph_sl, lim_ph_sh, lim_ph_wl, lim_ph_wh;
    int lim_sol_s, lim_sol_w, lim_tmp_s, lim_tmp_w;

    t_in  pending_readings[$];
    t_out expected_results[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   hold_output;
    bit   pause_sender;
    bit   stimulus_done;
    int   burst_left;
    int   gap_left;
    int   stall_mode;

    water_quality_scorer DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_in       (in_beat),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_out      (out_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Interpolated half-scale step, truncated.
    function automatic int half_step(int dlt, int span);
        if (span <= 0 || dlt <= 0) return 0;
        return (dlt * HALF_Q8) / span;
    endfunction

    // Danger score falling from half scale at the warning limit to 0 at the end.
    function automatic int falling_danger(int x, int a, int end_pt);
        int s;
        if (x >= end_pt) return 0;
        s = HALF_Q8 - half_step(x - a, end_pt - a);
        if (s < 0) s = 0;
        if (s > HALF_Q8) s = HALF_Q8;
        return s;
    endfunction

    // Classify a reading that only has upper limits.
    function automatic int grade_upper(int x, int safe_lim, int warn_lim, int end_pt,
                                       output logic [1:0] cls);
        if (x <= safe_lim) begin
            cls = ST_SAFE;
            return FULL_Q8;
        end
        if (x <= warn_lim) begin
            cls = ST_WARN;
            return FULL_Q8 - half_step(x - safe_lim, warn_lim - safe_lim);
        end
        cls = ST_DANGER;
        return falling_danger(x, warn_lim, end_pt);
    endfunction

    function automatic int grade_ph(int x, output logic [1:0] cls);
        if (x >= lim_ph_sl && x <= lim_ph_sh) begin
            cls = ST_SAFE;
            return FULL_Q8;
        end
        if (x >= lim_ph_wl && x < lim_ph_sl) begin
            cls = ST_WARN;
            return HALF_Q8 + half_step(x - lim_ph_wl, lim_ph_sl - lim_ph_wl);
        end
        if (x > lim_ph_sh && x <= lim_ph_wh) begin
            cls = ST_WARN;
            return FULL_Q8 - half_step(x - lim_ph_sh, lim_ph_wh - lim_ph_sh);
        end
        cls = ST_DANGER;
        if (x < lim_ph_wl) return half_step(x, lim_ph_wl);
        return falling_danger(x, lim_ph_wh, PH_END);
    endfunction

    // Full prediction of one result beat from one set of readings.
    function automatic t_out score_readings(t_in r);
        t_out        res;
        logic [1:0]  cls [4];
        logic        ok [4];
        int          sc [4];
        int          sum;
        int          cnt;
        logic [1:0]  worst;
        cls = '{ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL};
        sc = '{0, 0, 0, 0};
        ok = '{r.ph_ok, r.solids_ok, r.temp_ok, r.turbidity_ok};
        sum = 0;
        cnt = 0;
        worst = ST_SAFE;
        res = '0;
        if (r.ph_ok) sc[0] = grade_ph(int'(r.ph_value), cls[0]);
        if (r.solids_ok)
            sc[1] = grade_upper(int'(r.solids_ppm), lim_sol_s, lim_sol_w, SOLIDS_END, cls[1]);
        if (r.temp_ok)
            sc[2] = grade_upper(int'(r.temp_tenths), lim_tmp_s, lim_tmp_w, TEMP_END, cls[2]);
        if (r.turbidity_ok)
            sc[3] = grade_upper(int'(r.turbidity_ntu), TURB_SAFE_NTU, TURB_WARN_NTU,
                                TURB_END, cls[3]);
        for (int i = 0; i < 4; i++) begin
            if (ok[i]) begin
                sum += sc[i];
                cnt++;
                if (cls[i] > worst) worst = cls[i];
            end
        end
        if (cnt > 0) res.water_score = 7'(sum / (cnt * 256));
        else worst = ST_DANGER;
        if (r.ph_ok && cls[0] != ST_SAFE)
            res.reason_flags[int'(r.ph_value) < lim_ph_sl ? 0 : 1] = 1'b1;
        res.reason_flags[2] = r.solids_ok && cls[1] != ST_SAFE;
        res.reason_flags[3] = r.temp_ok && cls[2] != ST_SAFE;
        res.reason_flags[4] = r.turbidity_ok && cls[3] != ST_SAFE;
        res.water_status = worst;
        res.overall_status = (r.ph_ok && r.solids_ok && r.temp_ok && r.turbidity_ok)
                             ? worst : ST_FAIL;
        res.ph_status = cls[0];
        res.solids_status = cls[1];
        res.temp_status = cls[2];
        res.turbidity_status = cls[3];
        return res;
    endfunction

    function automatic t_in random_readings();
        t_in r;
        int  t;
        r.ph_value = 11'($urandom_range(0, 1400));
        r.solids_ppm = 12'($urandom);
        t = $urandom_range(0, 1650);
        r.temp_tenths = 12'(t - 400);
        r.turbidity_ntu = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                      : 10'($urandom_range(0, 120));
        // Mostly working sensors, with occasional faults.
        r.ph_ok = $urandom_range(0, 9) != 0;
        r.solids_ok = $urandom_range(0, 9) != 0;
        r.temp_ok = $urandom_range(0, 9) != 0;
        r.turbidity_ok = $urandom_range(0, 9) != 0;
        return r;
    endfunction

    function automatic t_in make_readings(int ph, int sol, int tmp, int tur, logic [3:0] ok);
        t_in r;
        r.ph_value = 11'(ph);
        r.solids_ppm = 12'(sol);
        r.temp_tenths = 12'(tmp);
        r.turbidity_ntu = 10'(tur);
        {r.ph_ok, r.solids_ok, r.temp_ok, r.turbidity_ok} = ok;
        return r;
    endfunction

    // Driver: bursts of beats with random gaps; a beat holds while stalled.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid) expected_results.push_back(score_readings(in_beat));
            if (pending_readings.size() == 0 || pause_sender) begin
                in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                in_valid <= 1'b1;
                in_beat <= pending_readings.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver stall pattern, switched now and then between styles.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= hold_output;
                1: out_stall <= hold_output || ($urandom_range(0, 3) == 0);
                2: out_stall <= hold_output || ($urandom_range(0, 1) == 0);
                default: out_stall <= hold_output || ($urandom_range(0, 7) < 6);
            endcase
        end
    end

    // Monitor and watchdog.
    always @(posedge clk) begin
        t_out want;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_water_quality_scorer: FAIL");
                $finish;
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_beat.water_score !== want.water_score) begin
                        $error("water_score exp %0d got %0d", want.water_score,
                               out_beat.water_score);
                        error_count++;
                    end
                    if (out_beat.water_status !== want.water_status) begin
                        $error("water_status exp %0d got %0d", want.water_status,
                               out_beat.water_status);
                        error_count++;
                    end
                    if (out_beat.overall_status !== want.overall_status) begin
                        $error("overall_status exp %0d got %0d", want.overall_status,
                               out_beat.overall_status);
                        error_count++;
                    end
                    if (out_beat.reason_flags !== want.reason_flags) begin
                        $error("reason_flags exp %b got %b", want.reason_flags,
                               out_beat.reason_flags);
                        error_count++;
                    end
                    if (out_beat.ph_status !== want.ph_status) begin
                        $error("ph_status exp %0d got %0d", want.ph_status,
                               out_beat.ph_status);
                        error_count++;
                    end
                    if (out_beat.solids_status !== want.solids_status) begin
                        $error("solids_status exp %0d got %0d", want.solids_status,
                               out_beat.solids_status);
                        error_count++;
                    end
                    if (out_beat.temp_status !== want.temp_status) begin
                        $error("temp_status exp %0d got %0d", want.temp_status,
                               out_beat.temp_status);
                        error_count++;
                    end
                    if (out_beat.turbidity_status !== want.turbidity_status) begin
                        $error("turbidity_status exp %0d got %0d", want.turbidity_status,
                               out_beat.turbidity_status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Wait until every queued beat is sent and every result has come back.
    task automatic drain_all();
        while (pending_readings.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [2:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= 12'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PH_SAFE_LOW:  lim_ph_sl = value & 12'h7FF;
            CFG_PH_SAFE_HIGH: lim_ph_sh = value & 12'h7FF;
            CFG_PH_WARN_LOW:  lim_ph_wl = value & 12'h7FF;
            CFG_PH_WARN_HIGH: lim_ph_wh = value & 12'h7FF;
            CFG_SOL_SAFE:     lim_sol_s = value & 12'hFFF;
            CFG_SOL_WARN:     lim_sol_w = value & 12'hFFF;
            CFG_TEMP_SAFE:    lim_tmp_s = int'($signed(12'(value)));
            default:          lim_tmp_w = int'($signed(12'(value)));
        endcase
    endtask

    task automatic write_all_limits(int psl, int psh, int pwl, int pwh,
                                    int ss, int sw, int ts, int tw);
        write_limit(CFG_PH_SAFE_LOW, psl);
        write_limit(CFG_PH_SAFE_HIGH, psh);
        write_limit(CFG_PH_WARN_LOW, pwl);
        write_limit(CFG_PH_WARN_HIGH, pwh);
        write_limit(CFG_SOL_SAFE, ss);
        write_limit(CFG_SOL_WARN, sw);
        write_limit(CFG_TEMP_SAFE, ts);
        write_limit(CFG_TEMP_WARN, tw);
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_readings.push_back(random_readings());
    endtask

    initial begin
        int hold_cycles;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_PH_SAFE_LOW;
        cfg_data = '0;
        hold_output = 1'b0;
        pause_sender = 1'b0;
        lim_ph_sl = 650;  lim_ph_sh = 850;  lim_ph_wl = 600;  lim_ph_wh = 900;
        lim_sol_s = 300;  lim_sol_w = 600;  lim_tmp_s = 300;  lim_tmp_w = 400;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every class, faults and no working sensor.
        pending_readings.push_back(make_readings(0, 0, -400, 0, 4'b1111));
        pending_readings.push_back(make_readings(1400, 4095, 1250, 1023, 4'b1111));
        pending_readings.push_back(make_readings(2047, 4095, -2048, 1023, 4'b1111));
        pending_readings.push_back(make_readings(700, 200, 250, 3, 4'b1111));
        pending_readings.push_back(make_readings(620, 450, 350, 7, 4'b1111));
        pending_readings.push_back(make_readings(880, 600, 400, 10, 4'b1111));
        pending_readings.push_back(make_readings(300, 800, 500, 50, 4'b1111));
        pending_readings.push_back(make_readings(1000, 1000, 600, 100, 4'b1111));
        pending_readings.push_back(make_readings(650, 300, 300, 5, 4'b1111));
        pending_readings.push_back(make_readings(850, 301, 301, 6, 4'b1111));
        pending_readings.push_back(make_readings(599, 999, 599, 99, 4'b1010));
        pending_readings.push_back(make_readings(950, 700, 450, 20, 4'b0101));
        pending_readings.push_back(make_readings(100, 3000, 1200, 500, 4'b0000));
        pending_readings.push_back(make_readings(1365, 2730, 1365, 682, 4'b1000));
        pending_readings.push_back(make_readings(682, 1365, 682, 341, 4'b0111));
        drain_all();

        // Random traffic with the reset limits, including a long receiver hold.
        queue_random(300);
        repeat (50) @(posedge clk);
        hold_output = 1'b1;
        for (hold_cycles = 0; hold_cycles < 200; hold_cycles++) @(posedge clk);
        hold_output = 1'b0;
        drain_all();

        // Sender pause until everything has come back, then resume.
        queue_random(200);
        repeat (100) @(posedge clk);
        pause_sender = 1'b1;
        while (expected_results.size() != 0) @(posedge clk);
        pause_sender = 1'b0;
        drain_all();

        // Extreme limits: everything at the top, signed temperature minimum.
        write_all_limits(1400, 1400, 1400, 1400, 4095, 4095, -400, 1250);
        queue_random(250);
        drain_all();

        // Extreme limits: everything at zero, temperature at its lowest.
        write_all_limits(0, 0, 0, 0, 0, 0, -400, -400);
        queue_random(250);
        drain_all();

        // Misordered limits: safe band outside the warning band.
        write_all_limits(900, 500, 1000, 400, 800, 200, 900, -100);
        queue_random(250);
        drain_all();

        // Wide ordered bands.
        write_all_limits(400, 1000, 100, 1300, 100, 3500, -200, 1000);
        queue_random(250);
        drain_all();

        // Random well-ordered settings.
        for (int k = 0; k < 4; k++) begin
            int a, b, c, d;
            a = $urandom_range(1, 1399);
            b = $urandom_range(a, 1400);
            d = $urandom_range(b, 1400);
            c = $urandom_range(0, 1650) - 400;
            write_all_limits(a, b, $urandom_range(0, a), d,
                             $urandom_range(0, 2000), $urandom_range(2000, 4095),
                             c, c + $urandom_range(0, 1250 - c));
            queue_random(100);
            drain_all();
        end

        if (error_count == 0) begin
            $display("tb_water_quality_scorer: PASS");
        end else begin
            $display("tb_water_quality_scorer: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
src/wqs_pkg.sv
src/wqs_div_lane.sv
src/water_quality_scorer.sv
test/tb_water_quality_scorer.sv
